// ----- rtl/mhpq_pkg.sv -----
// Shared types and constants of the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 11;
	localparam int ADDR_W   = $clog2(CAPACITY);
	// Child indices reach twice the capacity, so they get two spare bits.
	localparam int IDX_W    = ADDR_W + 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic                    kind;
		logic signed [KEY_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] removed_value;
		logic [CNT_W-1:0]        count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_DEL_A,
		S_DEL_B,
		S_DN_L,
		S_DN_R,
		S_DN_CMP
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/mhpq_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/min_heap_priority_queue_core.sv -----
// Top level of the min-heap priority queue: sequencer and datapath around the heap RAM.
`default_nettype none

// Binary min-heap of signed 32-bit keys held in one RAM of CAPACITY entries.
// A request is taken at a rising edge where start is high and busy is low;
// req.kind selects insert (req.value is the key) or delete of the minimum.
// Each request yields exactly one response: done is high for one cycle while
// rsp carries the status, the removed minimum (zero unless a delete
// succeeded) and the element count after the request. The receiver cannot
// stall the response, so done is a plain one-cycle strobe.
// The RAM has one write port and one registered read port, and every step of
// a sift goes through it. An insert climbs level by level, the read of the
// next parent overlapping the write of the current one. A delete walks down
// until it ends at a leaf or a child that is not smaller stops it; at each
// level the left and the right child are read one after the other, then
// compared and written back. An insert into an empty heap and the removal of
// the only element skip the sift, and refused requests (insert when full,
// delete when empty) never leave the idle state. Reset clears the count and
// the sequencer; the RAM needs no clearing since only entries below the count
// are read.
module min_heap_priority_queue_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire mhpq_pkg::req_t req,
	output logic               done,
	output mhpq_pkg::rsp_t     rsp
);

	import mhpq_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q;
	logic [ADDR_W-1:0]       pos_q;
	logic [ADDR_W-1:0]       par_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] removed_q;
	logic signed [KEY_W-1:0] lval_q;
	logic                    done_q;
	rsp_t                    rsp_q;

	// RAM port signals.
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [KEY_W-1:0]  wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [KEY_W-1:0]  rd_data;

	// Response formed in the cycle a request completes.
	logic                    fin;
	logic [1:0]              fin_status;
	logic signed [KEY_W-1:0] fin_removed;

	logic accept;
	logic is_full;
	logic is_empty;

	logic [ADDR_W-1:0] pos_m1;
	logic [ADDR_W-1:0] par_m1;
	logic [ADDR_W-1:0] pos_parent;
	logic [ADDR_W-1:0] par_parent;

	logic [IDX_W-1:0]        left_idx;
	logic [IDX_W-1:0]        right_idx;
	logic [IDX_W-1:0]        count_ext;
	logic                    has_left;
	logic                    has_right;
	logic                    take_right;
	logic [ADDR_W-1:0]       pick_idx;
	logic signed [KEY_W-1:0] pick_val;
	logic                    up_swap;
	logic                    dn_swap;

	mhpq_ram #(
		.WIDTH (KEY_W),
		.DEPTH (CAPACITY)
	) u_heap_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign is_full  = (count_q >= CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// Parent of an array index i is (i - 1) / 2.
	assign pos_m1     = pos_q - ADDR_W'(1);
	assign par_m1     = par_q - ADDR_W'(1);
	assign pos_parent = {1'b0, pos_m1[ADDR_W-1:1]};
	assign par_parent = {1'b0, par_m1[ADDR_W-1:1]};

	// Children of the current position, judged against the shrunken count.
	assign left_idx  = {{(IDX_W-ADDR_W-1){1'b0}}, pos_q, 1'b1};
	assign right_idx = left_idx + IDX_W'(1);
	assign count_ext = IDX_W'(count_q);
	assign has_left  = (left_idx < count_ext);
	assign has_right = (right_idx < count_ext);

	// Sift-down picks the left child unless the right one is strictly smaller.
	assign take_right = has_right && ($signed(rd_data) < lval_q);
	assign pick_idx   = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
	assign pick_val   = take_right ? $signed(rd_data) : lval_q;
	assign dn_swap    = (pick_val < key_q);

	// Sift-up moves on only past a strictly larger parent.
	assign up_swap = (key_q < $signed(rd_data));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_INSERT) begin
						if (!is_full) begin
							state_d = S_UP;
						end
					end else if (!is_empty) begin
						state_d = S_DEL_A;
					end
				end
			end
			S_UP: begin
				state_d = (pos_q == '0) ? S_IDLE : S_UP_CMP;
			end
			S_UP_CMP: begin
				if (!up_swap) begin
					state_d = S_IDLE;
				end else if (par_q == '0) begin
					state_d = S_UP;
				end
			end
			S_DEL_A: begin
				state_d = (count_q == '0) ? S_IDLE : S_DEL_B;
			end
			S_DEL_B: begin
				state_d = S_DN_L;
			end
			S_DN_L: begin
				state_d = has_left ? S_DN_R : S_IDLE;
			end
			S_DN_R: begin
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				state_d = dn_swap ? S_DN_L : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// RAM accesses and completion for each state.
	always_comb begin
		wr_en       = 1'b0;
		wr_addr     = pos_q;
		wr_data     = key_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		fin         = 1'b0;
		fin_status  = STATUS_OK;
		fin_removed = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_INSERT) begin
						if (is_full) begin
							fin        = 1'b1;
							fin_status = STATUS_FULL;
						end
					end else if (is_empty) begin
						fin        = 1'b1;
						fin_status = STATUS_EMPTY;
					end else begin
						// Fetch the root, which is the minimum to remove.
						rd_en   = 1'b1;
						rd_addr = '0;
					end
				end
			end
			S_UP: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
					fin   = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = pos_parent;
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (up_swap) begin
					// The parent moves down; the key stays in a register.
					wr_data = rd_data;
					if (par_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = par_parent;
					end
				end else begin
					fin = 1'b1;
				end
			end
			S_DEL_A: begin
				if (count_q == '0) begin
					fin         = 1'b1;
					fin_removed = $signed(rd_data);
				end else begin
					// Fetch the last element, which takes the root's place.
					rd_en   = 1'b1;
					rd_addr = count_q[ADDR_W-1:0];
				end
			end
			S_DEL_B: begin
				rd_en = 1'b0;
			end
			S_DN_L: begin
				if (has_left) begin
					rd_en   = 1'b1;
					rd_addr = left_idx[ADDR_W-1:0];
				end else begin
					wr_en       = 1'b1;
					fin         = 1'b1;
					fin_removed = removed_q;
				end
			end
			S_DN_R: begin
				rd_en   = 1'b1;
				rd_addr = right_idx[ADDR_W-1:0];
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (dn_swap) begin
					wr_data = pick_val;
				end else begin
					fin         = 1'b1;
					fin_removed = removed_q;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if ((state_q == S_IDLE) && accept) begin
				if (req.kind == KIND_INSERT) begin
					if (!is_full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end else if (!is_empty) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q <= count_q[ADDR_W-1:0];
					key_q <= req.value;
				end
			end
			S_UP: begin
				par_q <= pos_parent;
			end
			S_UP_CMP: begin
				if (up_swap) begin
					pos_q <= par_q;
					par_q <= par_parent;
				end
			end
			S_DEL_A: begin
				removed_q <= $signed(rd_data);
			end
			S_DEL_B: begin
				key_q <= $signed(rd_data);
				pos_q <= '0;
			end
			S_DN_L: begin
				lval_q <= lval_q;
			end
			S_DN_R: begin
				lval_q <= $signed(rd_data);
			end
			S_DN_CMP: begin
				if (dn_swap) begin
					pos_q <= pick_idx;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
		if (fin) begin
			rsp_q.status        <= fin_status;
			rsp_q.removed_value <= fin_removed;
			// The count register has already taken its new value by now,
			// except on the accept cycle of a refused request, where it holds.
			rsp_q.count         <= count_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// ----- tb/tb_min_heap_priority_queue_core.sv -----
// Self-checking testbench of the min-heap priority queue core.
`timescale 1ns / 1ps

// The testbench drives insert and delete requests into the core and keeps a
// heap model of its own in step with every accepted request. Each response
// strobe is checked field by field against the oldest outstanding
// expectation.
//
// The run opens with a short directed table. Rows whose answer is obvious
// carry a hand-typed response: an empty delete, the first inserts, and the
// removal of the extreme keys. All other rows take their expectation from
// the heap model. Random traffic follows in phases. The first phase is a
// mixed run with start held high. The second fills the heap to capacity
// while the sender idles at random, then pushes inserts into the full heap.
// The last two phases drain it with and without idle gaps. Keys are drawn
// from three pools: extremes, a narrow band that forces equal keys, and
// the full 32-bit range.
module tb_min_heap_priority_queue_core;
	import mhpq_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// One row of the directed table. When hand_typed is set, the row's
	// response is the expectation, and the heap model is still advanced.
	typedef struct packed {
		req_t r;
		bit   hand_typed;
		rsp_t want;
	} stim_row_t;

	stim_row_t stim_rows[$];

	// The testbench's own copy of the heap and its element count.
	logic signed [KEY_W-1:0] model_keys [CAPACITY];
	int                      model_count;

	// Responses still owed by the core, oldest first.
	rsp_t owed_rsps[$];
	int   mismatches;

	min_heap_priority_queue_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the heap model and return the response it earns.
	function automatic rsp_t heap_apply(req_t r);
		rsp_t                    res;
		int                      pos;
		int                      parent;
		int                      left;
		int                      right;
		int                      pick;
		bit                      moving;
		logic signed [KEY_W-1:0] tmp;
		res.status = STATUS_OK;
		res.removed_value = '0;
		if (r.kind == KIND_INSERT) begin
			if (model_count >= CAPACITY) begin
				res.status = STATUS_FULL;
			end else begin
				pos = model_count;
				model_keys[pos] = r.value;
				model_count++;
				// Climb while the parent is strictly larger.
				moving = 1'b1;
				while (moving && pos != 0) begin
					parent = (pos - 1) / 2;
					if (model_keys[pos] < model_keys[parent]) begin
						tmp = model_keys[pos];
						model_keys[pos] = model_keys[parent];
						model_keys[parent] = tmp;
						pos = parent;
					end else begin
						moving = 1'b0;
					end
				end
			end
		end else begin
			if (model_count == 0) begin
				res.status = STATUS_EMPTY;
			end else begin
				res.removed_value = model_keys[0];
				model_count--;
				model_keys[0] = model_keys[model_count];
				// Sink the new root. The left child wins ties between the children,
				// and an equal child stops the walk.
				pos = 0;
				moving = 1'b1;
				while (moving) begin
					left = 2 * pos + 1;
					right = left + 1;
					if (left >= model_count) begin
						moving = 1'b0;
					end else begin
						pick = left;
						if (right < model_count && model_keys[right] < model_keys[left]) begin
							pick = right;
						end
						if (model_keys[pick] < model_keys[pos]) begin
							tmp = model_keys[pick];
							model_keys[pick] = model_keys[pos];
							model_keys[pos] = tmp;
							pos = pick;
						end else begin
							moving = 1'b0;
						end
					end
				end
			end
		end
		res.count = CNT_W'(model_count);
		return res;
	endfunction

	// Keys come from three pools. Extremes and the narrow band around zero
	// make equal keys and sign boundaries common. The wide pool exercises
	// every bit.
	function automatic logic signed [KEY_W-1:0] pick_key();
		logic signed [KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: k = 32'sh8000_0000;
					1: k = 32'sh7FFF_FFFF;
					2: k = 32'sh0000_0000;
					default: k = 32'shFFFF_FFFF;
				endcase
			end
			1, 2, 3: k = $signed(32'($urandom_range(0, 15))) - 32'sd8;
			default: k = $signed($urandom());
		endcase
		return k;
	endfunction

	task automatic add_row(logic kind, logic [KEY_W-1:0] value, bit hand_typed,
			logic [1:0] status, logic [KEY_W-1:0] removed, int count);
		stim_row_t row;
		row.r.kind = kind;
		row.r.value = value;
		row.hand_typed = hand_typed;
		row.want.status = status;
		row.want.removed_value = removed;
		row.want.count = CNT_W'(count);
		stim_rows.insert(stim_rows.size(), row);
	endtask

	// Present a request at the falling edge and hold it until a rising edge
	// finds busy low. That edge is where the core takes the request, so the
	// heap model advances in step with it.
	task automatic send_request(req_t r, bit hand_typed, rsp_t want);
		rsp_t predicted;
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predicted = heap_apply(r);
		owed_rsps.insert(owed_rsps.size(), hand_typed ? want : predicted);
	endtask

	// Drop start for a random stretch. Most gaps are short. Now and then a
	// long gap outlasts a full sift.
	task automatic sender_gap(int idle_pct);
		int len;
		if ($urandom_range(0, 99) < idle_pct) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (len - 1) @(negedge clk);
		end
	endtask

	task automatic random_request(int insert_pct, int idle_pct);
		req_t r;
		rsp_t unused;
		unused = '0;
		r.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
		// A delete carries noise in its key field, which the core must ignore.
		r.value = (r.kind == KIND_INSERT) ? pick_key() : $signed($urandom());
		send_request(r, 1'b0, unused);
		sender_gap(idle_pct);
	endtask

	// Response checker. A strobe with nothing owed, or a field that differs,
	// counts as a failure, and the run carries on.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (owed_rsps.size() == 0) begin
				$error("response with no request outstanding: status %0d count %0d",
					rsp.status, rsp.count);
				mismatches++;
			end else begin
				want = owed_rsps.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.removed_value !== want.removed_value) begin
					$error("removed_value: expected %0d, got %0d",
						want.removed_value, rsp.removed_value);
					mismatches++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp.count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		model_count = 0;
		mismatches = 0;

		// Directed table. The heap starts empty. Delete rows carry garbage in the
		// key field.
		add_row(KIND_DELETE, 32'hDEAD_BEEF, 1'b1, STATUS_EMPTY, 32'h0, 0);
		add_row(KIND_INSERT, 32'h7FFF_FFFF, 1'b1, STATUS_OK, 32'h0, 1);
		add_row(KIND_INSERT, 32'h8000_0000, 1'b1, STATUS_OK, 32'h0, 2);
		add_row(KIND_INSERT, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'h0000_0005, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'h0000_0005, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'h0000_0005, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'hFFFF_FFFF, 1'b0, STATUS_OK, 32'h0, 0);
		// The most negative key must surface first.
		add_row(KIND_DELETE, 32'hFFFF_FFFF, 1'b1, STATUS_OK, 32'h8000_0000, 7);
		add_row(KIND_DELETE, 32'h1234_5678, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h8000_0000, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h7FFF_FFFF, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h5555_AAAA, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h0F0F_F0F0, 1'b0, STATUS_OK, 32'h0, 0);
		// Removing the last element leaves the largest key and an empty heap.
		add_row(KIND_DELETE, 32'hAAAA_5555, 1'b1, STATUS_OK, 32'h7FFF_FFFF, 0);
		add_row(KIND_DELETE, 32'h0000_0001, 1'b1, STATUS_EMPTY, 32'h0, 0);
		// With three equal keys, the first delete leaves the new root tied with its only child.
		add_row(KIND_INSERT, 32'h0000_0003, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'h0000_0003, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_INSERT, 32'h0000_0003, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'h0000_0000, 1'b0, STATUS_OK, 32'h0, 0);
		add_row(KIND_DELETE, 32'hFFFF_FFFF, 1'b1, STATUS_EMPTY, 32'h0, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stim_rows.size(); i++) begin
			row = stim_rows[i];
			send_request(row.r, row.hand_typed, row.want);
		end

		// Mixed traffic with start held high, so requests arrive back to back.
		repeat (20) random_request(60, 0);

		// Fill the heap to capacity while the sender idles about half the time.
		// Then push inserts into the full heap.
		while (model_count < CAPACITY) random_request(99, 46);
		repeat (6) random_request(100, 46);

		// The receiver cannot stall a response, so this phase runs without gaps.
		// Deletes dominate.
		repeat (12) random_request(30, 0);

		// Drain further with the sender idle about a third of the time.
		repeat (16) random_request(35, 35);

		@(negedge clk);
		start <= 1'b0;
		while (owed_rsps.size() != 0) @(posedge clk);
		// A stray response would show up within the slowest delete.
		repeat (60) @(posedge clk);

		if (mismatches == 0) begin
			$display("min_heap_priority_queue_core test passed");
		end else begin
			$display("min_heap_priority_queue_core test failed");
		end
		$finish;
	end

	// Watchdog. It allows several times the slowest legal run.
	initial begin
		#5_000_000;
		$display("min_heap_priority_queue_core test failed");
		$finish;
	end

endmodule

// ----- min_heap_priority_queue_core.f -----
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/min_heap_priority_queue_core.sv
tb/tb_min_heap_priority_queue_core.sv
